// File: rtl/core/iewe_pkg.sv
// ----------------------------------------------------------------------------
// iewe_pkg
// Shared types and constants for the input event word encoder.
// ----------------------------------------------------------------------------
package iewe_pkg;

    // event kinds
    localparam logic [1:0] OP_MOVE     = 2'd0;
    localparam logic [1:0] OP_BTN_DOWN = 2'd1;
    localparam logic [1:0] OP_BTN_UP   = 2'd2;
    localparam logic [1:0] OP_KEY      = 2'd3;

    // mouse button selects
    localparam logic [1:0] BTN_RED    = 2'd0;
    localparam logic [1:0] BTN_YELLOW = 2'd1;
    localparam logic [1:0] BTN_BLUE   = 2'd2;

    // word types
    localparam logic [3:0] TYPE_DELTA_TIME = 4'd0;
    localparam logic [3:0] TYPE_X_COORD    = 4'd1;
    localparam logic [3:0] TYPE_Y_COORD    = 4'd2;
    localparam logic [3:0] TYPE_BI_DOWN    = 4'd3;
    localparam logic [3:0] TYPE_BI_UP      = 4'd4;
    localparam logic [3:0] TYPE_ABS_TIME   = 4'd5;

    // button codes
    localparam logic [11:0] CODE_RED    = 12'd130;
    localparam logic [11:0] CODE_YELLOW = 12'd129;
    localparam logic [11:0] CODE_BLUE   = 12'd128;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [1:0]  button;
        logic [11:0] char_code;
        logic [31:0] now_ms;
        logic [31:0] epoch_time;
    } event_t;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } result_t;

    // classified event handed from the front to the back
    typedef struct packed {
        logic        abs_time;
        logic [15:0] time_word;
        logic [31:0] epoch;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
        logic        has_word3;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_TIME,
        ST_EPOCH_HI,
        ST_EPOCH_LO,
        ST_WORD1,
        ST_WORD2,
        ST_WORD3
    } seq_state_t;

endpackage

// File: rtl/core/iewe_front.sv
// ----------------------------------------------------------------------------
// iewe_front
// Accepts events, tracks the previous event time and classifies each event
// into a command for the word sequencer.
// ----------------------------------------------------------------------------
module iewe_front
    import iewe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   ev_valid,
    output logic   ev_stall,
    input  event_t ev_data,
    input  logic   q_full,
    output logic   q_push,
    output cmd_t   q_cmd
);

    logic [31:0] last_ms_reg;
    logic [31:0] last_ms_next;
    logic        first_reg;
    logic        first_next;
    logic [31:0] delta;
    logic [11:0] btn_code;
    logic        accept;

    assign ev_stall = q_full;
    assign accept   = ev_valid && !q_full;
    assign q_push   = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ms_reg <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            last_ms_reg <= last_ms_next;
            first_reg   <= first_next;
        end
    end

    always_comb
    begin
        last_ms_next = last_ms_reg;
        first_next   = first_reg;
        if (accept)
        begin
            last_ms_next = ev_data.now_ms;
            first_next   = 1'b0;
        end
    end

    // wrapping difference, zero on the first event
    assign delta = first_reg ? 32'd0 : (ev_data.now_ms - last_ms_reg);

    always_comb
    begin
        unique case (ev_data.button)
            BTN_YELLOW: btn_code = CODE_YELLOW;
            BTN_BLUE:   btn_code = CODE_BLUE;
            default:    btn_code = CODE_RED;
        endcase
    end

    always_comb
    begin
        q_cmd.abs_time  = |delta[31:12];
        q_cmd.time_word = q_cmd.abs_time ? {TYPE_ABS_TIME, 12'd0}
                                         : {TYPE_DELTA_TIME, delta[11:0]};
        q_cmd.epoch     = ev_data.epoch_time;
        q_cmd.word1     = {TYPE_X_COORD, ev_data.pos_x};
        q_cmd.word2     = {TYPE_Y_COORD, ev_data.pos_y};
        q_cmd.word3     = {TYPE_BI_DOWN, btn_code};
        q_cmd.has_word3 = 1'b0;
        unique case (ev_data.op)
            OP_KEY:
            begin
                q_cmd.word1 = {TYPE_BI_DOWN, ev_data.char_code};
                q_cmd.word2 = {TYPE_BI_UP, ev_data.char_code};
            end
            OP_BTN_DOWN:
            begin
                q_cmd.has_word3 = 1'b1;
            end
            OP_BTN_UP:
            begin
                q_cmd.word3     = {TYPE_BI_UP, btn_code};
                q_cmd.has_word3 = 1'b1;
            end
            default:
            begin
                q_cmd.has_word3 = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/iewe_queue.sv
// ----------------------------------------------------------------------------
// iewe_queue
// Two-entry command queue between the front and the word sequencer.
// ----------------------------------------------------------------------------
module iewe_queue
    import iewe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full       = count_reg[1];
    assign head_valid = |count_reg;
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

endmodule

// File: rtl/core/iewe_back.sv
// ----------------------------------------------------------------------------
// iewe_back
// Word sequencer: walks the head command one word per cycle into the
// output register, while that register is not held by res_stall.
// ----------------------------------------------------------------------------
module iewe_back
    import iewe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  cmd_t    head_cmd,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    seq_state_t state_reg;
    seq_state_t state_next;
    logic       valid_reg;
    logic       valid_next;
    result_t    data_reg;
    result_t    data_next;
    logic       advance;

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    // output register is free when empty or being taken this cycle
    assign advance = head_valid && (!valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TIME;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        valid_next     = valid_reg && res_stall;
        pop            = 1'b0;
        data_next.word = head_cmd.time_word;
        data_next.last = 1'b0;
        unique case (state_reg)
            ST_TIME:
            begin
                data_next.word = head_cmd.time_word;
                state_next     = head_cmd.abs_time ? ST_EPOCH_HI : ST_WORD1;
            end
            ST_EPOCH_HI:
            begin
                data_next.word = head_cmd.epoch[31:16];
                state_next     = ST_EPOCH_LO;
            end
            ST_EPOCH_LO:
            begin
                data_next.word = head_cmd.epoch[15:0];
                state_next     = ST_WORD1;
            end
            ST_WORD1:
            begin
                data_next.word = head_cmd.word1;
                state_next     = ST_WORD2;
            end
            ST_WORD2:
            begin
                data_next.word = head_cmd.word2;
                data_next.last = !head_cmd.has_word3;
                state_next     = head_cmd.has_word3 ? ST_WORD3 : ST_TIME;
            end
            ST_WORD3:
            begin
                data_next.word = head_cmd.word3;
                data_next.last = 1'b1;
                state_next     = ST_TIME;
            end
            default:
            begin
                state_next = ST_TIME;
            end
        endcase
        if (advance)
        begin
            valid_next = 1'b1;
            pop        = data_next.last;
        end
        else
        begin
            state_next = state_reg;
            data_next  = data_reg;
        end
    end

endmodule

// File: rtl/core/input_event_word_encoder.sv
// a request is queued, then its first word is registered onto res_data
// throughput: one output word per cycle while res_stall is low, 3 to 6 words
// per request (words go out of the sequencer into the output register)
// a two-entry command queue lets up to two requests be taken while words drain
// reset (rst_n low, asynchronous) empties the queue and output, and restores
// the first-event state so the next time delta is zero
// ----------------------------------------------------------------------------
// input_event_word_encoder
// Encodes mouse, button and key requests into 16-bit input words.
// ----------------------------------------------------------------------------
module input_event_word_encoder
    import iewe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    ev_valid,
    output logic    ev_stall,
    input  event_t  ev_data,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    iewe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev_stall (ev_stall),
        .ev_data  (ev_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    iewe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    iewe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// File: rtl/core/iewe_checker.sv
// ----------------------------------------------------------------------------
// iewe_checker
// Port-level checks for the input event word encoder, bound to the top level.
// ----------------------------------------------------------------------------
module iewe_checker
    import iewe_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    ev_valid,
    input logic    ev_stall,
    input logic    res_valid,
    input logic    res_stall,
    input result_t res_data
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic [2:0] words_reg;
    logic [2:0] words_next;
    logic       ev_acc;
    logic       res_acc;
    logic       done;

    assign ev_acc  = ev_valid && !ev_stall;
    assign res_acc = res_valid && !res_stall;
    assign done    = res_acc && res_data.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            words_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            words_reg   <= words_next;
        end
    end

    always_comb
    begin
        pending_next = pending_reg + {2'd0, ev_acc} - {2'd0, done};
        words_next   = words_reg;
        if (res_acc)
        begin
            words_next = res_data.last ? 3'd0 : words_reg + 3'd1;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("stalled result changed");

    a_no_orphan_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> pending_reg != 3'd0)
        else $error("word delivered with no request outstanding");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (words_reg >= 3'd2 && words_reg <= 3'd5))
        else $error("request produced a word count outside 3 to 6");

endmodule

bind input_event_word_encoder iewe_checker u_checker (.*);
